// File: rtl/rrtp_pkg.sv
// ----------------------------------------------------------------------------
// rrtp_pkg
// Shared types and constants for the round-robin task picker.
// ----------------------------------------------------------------------------
package rrtp_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int CFG_W     = 4;
  localparam int OUT_IDX_W = 3;
  localparam int TIME_W    = 32;
  localparam int LEN_W     = 15;
  localparam int DLY_W     = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_END   = 2'd1,
    REQ_DELAY = 2'd2,
    REQ_SCHED = 2'd3
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } dly_entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    dly_entry_t       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } dmem_req_t;

endpackage

// File: rtl/rrtp_dly_mem.sv
// ----------------------------------------------------------------------------
// rrtp_dly_mem
// Delay start/length table, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrtp_dly_mem
  import rrtp_pkg::*;
(
  input  logic       clk,
  input  dmem_req_t  req,
  output dly_entry_t rd_data
);

  dly_entry_t mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: rtl/rrtp_ctrl.sv
// ----------------------------------------------------------------------------
// rrtp_ctrl
// Request sequencer: slot flags, current task, and the slot scan that
// serves add and schedule requests.
// ----------------------------------------------------------------------------
module rrtp_ctrl
  import rrtp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_req_type,
  input  logic signed [DLY_W-1:0] in_delay_ms,
  input  logic [TIME_W-1:0]       in_now_ms,
  input  logic [CNT_W-1:0]        eff_count,
  output dmem_req_t               mem_req,
  input  dly_entry_t              mem_rd_data,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        out_idx,
  output logic                    out_ok
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  req_t                op_r, op_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]    chk_pos_r, chk_pos_nxt;
  logic [MAX_TASKS-1:0] used_r, used_nxt;
  logic [MAX_TASKS-1:0] act_r, act_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic             accept;
  logic             arm;
  logic             expired;
  logic             hit;
  logic [CNT_W-1:0] cur_inc;
  logic [CNT_W-1:0] pos_inc;
  logic [IDX_W-1:0] scan_first;
  logic [IDX_W-1:0] pos_wrap;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign arm    = !in_delay_ms[DLY_W-1] && (in_delay_ms != '0);

  assign cur_inc    = CNT_W'(cur_r) + CNT_W'(1);
  assign scan_first = (cur_inc >= eff_count) ? '0 : IDX_W'(cur_inc);
  assign pos_inc    = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_wrap   = (pos_inc >= eff_count) ? '0 : IDX_W'(pos_inc);

  assign expired = (now_r - mem_rd_data.start) > TIME_W'(mem_rd_data.len);

  always_comb begin
    if (op_r == REQ_ADD) begin
      hit = chk_v_r && !used_r[chk_pos_r];
    end else begin
      hit = chk_v_r && used_r[chk_pos_r] && (!act_r[chk_pos_r] || expired);
    end
  end

  always_comb begin
    mem_req.wr_en         = accept && (req_t'(in_req_type) == REQ_DELAY) && arm;
    mem_req.wr_addr       = cur_r;
    mem_req.wr_data.start = in_now_ms;
    mem_req.wr_data.len   = in_delay_ms[LEN_W-1:0];
    mem_req.rd_en         = (state_r == ST_SCAN) && (left_r != '0);
    mem_req.rd_addr       = pos_r;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    chk_v_nxt     = 1'b0;
    chk_pos_nxt   = chk_pos_r;
    used_nxt      = used_r;
    act_nxt       = act_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_ok_nxt    = out_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = req_t'(in_req_type);
          now_nxt = in_now_ms;
          case (req_t'(in_req_type))
            REQ_ADD: begin
              pos_nxt   = '0;
              left_nxt  = eff_count;
              state_nxt = ST_SCAN;
            end
            REQ_END: begin
              used_nxt[cur_r] = 1'b0;
              out_valid_nxt   = 1'b1;
              out_idx_nxt     = cur_r;
              out_ok_nxt      = 1'b1;
            end
            REQ_DELAY: begin
              act_nxt[cur_r] = arm;
              out_valid_nxt  = 1'b1;
              out_idx_nxt    = cur_r;
              out_ok_nxt     = 1'b1;
            end
            REQ_SCHED: begin
              pos_nxt   = scan_first;
              left_nxt  = eff_count;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          act_nxt[chk_pos_r] = 1'b0;
          if (op_r == REQ_ADD) begin
            used_nxt[chk_pos_r] = 1'b1;
          end else begin
            cur_nxt = chk_pos_r;
          end
          out_valid_nxt = 1'b1;
          out_idx_nxt   = chk_pos_r;
          out_ok_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (left_r != '0) begin
          chk_v_nxt   = 1'b1;
          chk_pos_nxt = pos_r;
          pos_nxt     = pos_wrap;
          left_nxt    = left_r - CNT_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = (op_r == REQ_ADD) ? '0 : cur_r;
          out_ok_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= REQ_ADD;
      cur_r       <= '0;
      chk_v_r     <= 1'b0;
      used_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cur_r       <= cur_nxt;
      chk_v_r     <= chk_v_nxt;
      used_r      <= used_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      now_r       <= now_nxt;
      pos_r       <= pos_nxt;
      left_r      <= left_nxt;
      chk_pos_r   <= chk_pos_nxt;
      out_idx_r   <= out_idx_nxt;
      out_ok_r    <= out_ok_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_ok    = out_ok_r;

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while scanning");

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == ST_IDLE))
    else $error("delay table write during scan");

  a_sched_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r && (op_r == REQ_SCHED)) |-> (cur_r == out_idx_r))
    else $error("picked task is not current task");

  a_add_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r && (op_r == REQ_ADD)) |-> used_r[out_idx_r])
    else $error("added slot not marked used");

  a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_SCAN) |-> ((op_r == REQ_ADD) || (op_r == REQ_SCHED)))
    else $error("scan started for end or delay request");
`endif

endmodule

// File: rtl/round_robin_task_picker.sv
// ----------------------------------------------------------------------------
// round_robin_task_picker
// Task slot table with per-task delay and a round-robin schedule scan.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in_      start & !busy           in_req_type, in_delay_ms, in_now_ms
//  out_     out_valid (1 cycle)     out_task_index, out_ok
//  cfg_     cfg_valid & cfg_ready   cfg_data (task_count)
//
//  End and delay: result in the cycle after accept, next request taken at once.
//  Add and schedule: one slot per cycle through the delay table read port;
//  busy until a hit, or until every slot has been checked.
//  Reset clears all slot flags, the current task and task_count to 8.
//  The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module round_robin_task_picker
  import rrtp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_req_type,
  input  logic signed [DLY_W-1:0] in_delay_ms,
  input  logic [TIME_W-1:0]       in_now_ms,
  output logic                    out_valid,
  output logic [OUT_IDX_W-1:0]    out_task_index,
  output logic                    out_ok,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [CFG_W-1:0] task_count_r;
  logic [CNT_W-1:0] eff_count;
  dmem_req_t        mem_req;
  dly_entry_t       mem_rd_data;
  logic [IDX_W-1:0] out_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      task_count_r <= cfg_data;
    end
  end

  assign eff_count = (32'(task_count_r) > 32'(MAX_TASKS)) ?
                     CNT_W'(MAX_TASKS) : CNT_W'(task_count_r);

  rrtp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_delay_ms (in_delay_ms),
    .in_now_ms   (in_now_ms),
    .eff_count   (eff_count),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .out_valid   (out_valid),
    .out_idx     (out_idx),
    .out_ok      (out_ok)
  );

  rrtp_dly_mem u_dly_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  assign out_task_index = OUT_IDX_W'(out_idx);

endmodule

// File: bench/tb_round_robin_task_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_picker
// Self-checking bench for the round-robin task picker. A directed table hits
// the empty and full table, end and delay on free slots, the delay sign and
// magnitude extremes, and time wrap. Random phases then run under task counts
// 0-9 and 15, mostly with random request gaps. Results are compared field by
// field with a cycle-free slot table model in the bench, or a typed row's answer.
// ----------------------------------------------------------------------------
module tb_round_robin_task_picker;
  import rrtp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 55;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    req_t        req;
    logic [15:0] dly;
    logic [31:0] now;
    logic        typed;
    logic [2:0]  idx;
    logic        ok;
  } dir_row_t;

  typedef struct {
    logic [2:0] idx;
    logic       ok;
  } pick_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_req_type;
  logic signed [DLY_W-1:0] in_delay_ms;
  logic [TIME_W-1:0]       in_now_ms;
  logic                    out_valid;
  logic [OUT_IDX_W-1:0]    out_task_index;
  logic                    out_ok;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data;

  // Known answer riding along with each request (directed rows only)
  logic       typed_valid;
  logic [2:0] typed_idx;
  logic       typed_ok;

  // Bench copy of the slot table
  logic [3:0]  model_count;
  logic        model_used [MAX_TASKS];
  logic        model_armed [MAX_TASKS];
  logic [31:0] model_start [MAX_TASKS];
  logic [14:0] model_len [MAX_TASKS];
  logic [2:0]  model_cur;

  pick_t    expected_picks [$];
  int       mismatch_count;
  int       cycle_count;
  logic     idle_on;
  logic [31:0] clock_ms;
  dir_row_t directed_rows [24];

  round_robin_task_picker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_delay_ms    (in_delay_ms),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_task_index (out_task_index),
    .out_ok         (out_ok),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic predict_pick(input req_t req, input logic [15:0] dly,
                              input logic [31:0] now, output pick_t res);
    int          cnt;
    int          pos;
    logic [31:0] elapsed;
    logic        hit;
    cnt = (model_count > MAX_TASKS) ? MAX_TASKS : int'(model_count);
    res.idx = model_cur;
    res.ok = 1'b1;
    case (req)
      REQ_ADD: begin
        res.idx = 3'd0;
        res.ok = 1'b0;
        for (int i = 0; i < cnt; i++) begin
          if (!res.ok && !model_used[i]) begin
            model_used[i] = 1'b1;
            model_armed[i] = 1'b0;
            res.idx = 3'(i);
            res.ok = 1'b1;
          end
        end
      end
      REQ_END: model_used[model_cur] = 1'b0;
      REQ_DELAY: begin
        if (dly[15] || dly == 16'd0) begin
          model_armed[model_cur] = 1'b0;
        end else begin
          model_armed[model_cur] = 1'b1;
          model_start[model_cur] = now;
          model_len[model_cur] = dly[14:0];
        end
      end
      default: begin
        res.ok = 1'b0;
        pos = int'(model_cur) + 1;
        if (pos >= cnt) pos = 0;
        for (int i = 0; i < cnt; i++) begin
          if (!res.ok) begin
            elapsed = now - model_start[pos];
            hit = model_used[pos] && (!model_armed[pos] || elapsed > 32'(model_len[pos]));
            if (hit) begin
              model_armed[pos] = 1'b0;
              model_cur = 3'(pos);
              res.idx = 3'(pos);
              res.ok = 1'b1;
            end else begin
              pos++;
              if (pos >= cnt) pos = 0;
            end
          end
        end
      end
    endcase
  endtask

  // Model update on accepted transactions, and result check
  always @(posedge clk) begin
    pick_t res;
    pick_t want;
    if (!rst_n) begin
      model_count = CFG_RESET;
      model_cur = 3'd0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        model_used[i] = 1'b0;
        model_armed[i] = 1'b0;
        model_start[i] = 32'd0;
        model_len[i] = 15'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) model_count = cfg_data;
      if (start && !busy) begin
        predict_pick(req_t'(in_req_type), in_delay_ms, in_now_ms, res);
        if (typed_valid) begin
          res.idx = typed_idx;
          res.ok = typed_ok;
        end
        expected_picks.push_back(res);
      end
      if (out_valid) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("unexpected result, task_index", 32'(out_task_index), 0);
        end else begin
          want = expected_picks.pop_front();
          if (out_task_index !== want.idx)
            report_mismatch("task_index", 32'(out_task_index), 32'(want.idx));
          if (out_ok !== want.ok)
            report_mismatch("ok", 32'(out_ok), 32'(want.ok));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d results outstanding", $time, expected_picks.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Called at a rising edge; returns once the request is accepted and busy is low
  task automatic issue(input req_t req, input logic [15:0] dly, input logic [31:0] now,
                       input logic typed, input logic [2:0] idx, input logic ok);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_delay_ms <= dly;
    in_now_ms <= now;
    typed_valid <= typed;
    typed_idx <= idx;
    typed_ok <= ok;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_task_count(input logic [3:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic issue_random();
    int          k;
    req_t        req;
    logic [15:0] dly;
    k = $urandom_range(0, 99);
    if (k < 25) req = REQ_ADD;
    else if (k < 40) req = REQ_END;
    else if (k < 65) req = REQ_DELAY;
    else req = REQ_SCHED;
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 24);
    k = $urandom_range(0, 99);
    if (k < 60) dly = 16'($urandom_range(1, 40));
    else if (k < 70) dly = 16'd0;
    else if (k < 80) dly = {1'b1, 15'($urandom())};
    else if (k < 90) dly = (k < 84) ? 16'h7FFF : (k < 87) ? 16'h8000 : 16'd1;
    else dly = 16'($urandom());
    issue(req, dly, clock_ms, 1'b0, 3'd0, 1'b0);
  endtask

  initial begin
    logic [3:0] phase_counts [11];
    mismatch_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    clock_ms = 32'd0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= REQ_ADD;
    in_delay_ms <= '0;
    in_now_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    typed_valid <= 1'b0;
    typed_idx <= '0;
    typed_ok <= 1'b0;

    directed_rows = '{
      '{REQ_SCHED, 16'h0000, 32'h0000_0000, 1'b1, 3'd0, 1'b0},
      '{REQ_END,   16'h0000, 32'h0000_0000, 1'b1, 3'd0, 1'b1},
      '{REQ_DELAY, 16'h8000, 32'h0000_0000, 1'b1, 3'd0, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd0, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd1, 1'b1},
      '{REQ_DELAY, 16'h7FFF, 32'hFFFF_FFFF, 1'b1, 3'd0, 1'b1},
      '{REQ_SCHED, 16'h0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
      '{REQ_DELAY, 16'h0001, 32'h0000_0010, 1'b0, 3'd0, 1'b0},
      '{REQ_SCHED, 16'h0000, 32'h0000_0011, 1'b0, 3'd0, 1'b0},
      '{REQ_SCHED, 16'h0000, 32'h0000_0012, 1'b0, 3'd0, 1'b0},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd2, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd3, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd4, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd5, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd6, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd7, 1'b1},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b1, 3'd0, 1'b0},
      '{REQ_DELAY, 16'h8001, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
      '{REQ_DELAY, 16'h0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
      '{REQ_SCHED, 16'h0000, 32'h8000_0000, 1'b0, 3'd0, 1'b0},
      '{REQ_END,   16'h0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
      '{REQ_SCHED, 16'h0000, 32'hFFFF_FFFF, 1'b0, 3'd0, 1'b0},
      '{REQ_ADD,   16'h0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
      '{REQ_SCHED, 16'h0000, 32'h0000_7FFF, 1'b0, 3'd0, 1'b0}
    };
    phase_counts = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd9, 4'd5, 4'd3, 4'd4, 4'd7, 4'd6};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].dly, directed_rows[i].now,
            directed_rows[i].typed, directed_rows[i].idx, directed_rows[i].ok);

    foreach (phase_counts[p]) begin
      write_task_count(phase_counts[p]);
      idle_on = ($urandom_range(0, 3) != 0);
      clock_ms = $urandom();
      repeat (PHASE_ITEMS) issue_random();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
